[rtl/core/header_length_checksum_deframer_defines.svh]
// Assertion macros for the header/length/checksum deframer.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef HEADER_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`define HEADER_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define HLCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define HLCD_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/hlcd_pkg.sv]
// Shared types and constants for the header/length/checksum deframer.
// No dependencies.
package hlcd_pkg;

    localparam int LENGTH_BITS = 8;
    localparam int BYTE_BITS   = 8;

    typedef logic [LENGTH_BITS-1:0] t_len;
    typedef logic [BYTE_BITS-1:0]   t_byte;

    localparam t_byte HEADER_RESET = t_byte'(8'hAA);
    localparam t_len  MIN_LENGTH   = t_len'(3);

    // Parser phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    // Input stage contents handed to the parser
    typedef struct packed {
        logic  valid;
        t_byte data;
    } t_stage;

    // One parser result
    typedef struct packed {
        logic  valid;
        t_byte data;
        t_byte index;
        logic  last;
        logic  good;
    } t_result;

endpackage

[rtl/core/hlcd_in_reg.sv]
// Input register stage of the deframer: captures one received byte.
// Depends on hlcd_pkg.
module hlcd_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tvalid,
    input  hlcd_pkg::t_byte i_tdata,
    output logic            o_tready,
    input  logic            i_advance,  // stage contents consumed this cycle
    output hlcd_pkg::t_stage o_stage
);

    logic            r_valid;
    hlcd_pkg::t_byte r_data;

    assign o_tready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tready) begin
            r_valid <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_data <= i_tdata;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_data;

endmodule

[rtl/core/hlcd_parser.sv]
// Packet parser: phase, length, count and running checksum state.
// Holds the header_value register. Depends on hlcd_pkg.
module hlcd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  hlcd_pkg::t_byte   i_cfg_wr_data,
    input  hlcd_pkg::t_stage  i_stage,
    input  logic              i_advance,
    output hlcd_pkg::t_result o_result
);

    logic [1:0]      r_phase,   n_phase;
    hlcd_pkg::t_len  r_exp_len, n_exp_len;
    hlcd_pkg::t_len  r_count,   n_count;
    hlcd_pkg::t_byte r_sum,     n_sum;
    hlcd_pkg::t_byte r_header;

    hlcd_pkg::t_byte b;
    hlcd_pkg::t_len  b_len;
    hlcd_pkg::t_len  last_idx;

    assign b        = i_stage.data;
    assign b_len    = hlcd_pkg::t_len'(b);
    assign last_idx = hlcd_pkg::t_len'(r_exp_len - hlcd_pkg::t_len'(1));

    always_comb begin
        n_phase   = r_phase;
        n_exp_len = r_exp_len;
        n_count   = r_count;
        n_sum     = r_sum;
        o_result  = '0;
        o_result.data = b;
        unique case (r_phase)
            hlcd_pkg::PH_LEN: begin
                n_exp_len      = b_len;
                o_result.valid = 1'b1;
                o_result.index = hlcd_pkg::t_byte'(1);
                if (b_len < hlcd_pkg::MIN_LENGTH) begin
                    // too short: end packet on the length byte, marked bad
                    o_result.last = 1'b1;
                    n_phase       = hlcd_pkg::PH_IDLE;
                end else begin
                    n_sum   = r_sum + b;
                    n_count = hlcd_pkg::t_len'(2);
                    n_phase = hlcd_pkg::PH_BODY;
                end
            end
            hlcd_pkg::PH_BODY: begin
                o_result.valid = 1'b1;
                o_result.index = r_count[hlcd_pkg::BYTE_BITS-1:0];
                if (r_count == last_idx) begin
                    o_result.last = 1'b1;
                    o_result.good = (r_sum == b);
                    n_phase       = hlcd_pkg::PH_IDLE;
                end else begin
                    n_sum   = r_sum + b;
                    n_count = r_count + hlcd_pkg::t_len'(1);
                end
            end
            default: begin
                // idle and the unused code hunt for the header
                n_phase = hlcd_pkg::PH_IDLE;
                if (b == r_header) begin
                    o_result.valid = 1'b1;
                    n_sum     = b;
                    n_count   = hlcd_pkg::t_len'(1);
                    n_exp_len = '0;
                    n_phase   = hlcd_pkg::PH_LEN;
                end
            end
        endcase
        o_result.valid = o_result.valid && i_stage.valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= hlcd_pkg::PH_IDLE;
            r_exp_len <= '0;
            r_count   <= '0;
            r_sum     <= '0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_exp_len <= n_exp_len;
            r_count   <= n_count;
            r_sum     <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= hlcd_pkg::HEADER_RESET;
        end else if (i_cfg_wr_en) begin
            r_header <= i_cfg_wr_data;
        end
    end

endmodule

[rtl/core/hlcd_out_reg.sv]
// Result register of the deframer, drives the master-side stream.
// Depends on hlcd_pkg.
module hlcd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  hlcd_pkg::t_result i_result,
    output logic              o_can_load,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [15:0]       o_tdata,
    output logic              o_tlast,
    output logic [0:0]        o_tuser
);

    logic              r_valid;
    hlcd_pkg::t_result r_res;

    assign o_can_load = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_result;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {r_res.index, r_res.data};
    assign o_tlast  = r_res.last;
    assign o_tuser  = r_res.good;

endmodule

[rtl/core/header_length_checksum_deframer.sv]
// Header/length/additive-checksum deframer. Bytes are dropped until one equals
// header_value (reset 0xAA); the next byte is the total packet length, counting
// header, length and checksum bytes. Every packet byte is passed out with its
// index; the last one has tlast set and tuser high when it equals the low 8 bits
// of the sum of all earlier packet bytes. A length below 3 ends the packet on
// the length byte, marked bad. One byte per cycle is sustained: a byte is held in
// the input register until the parser's single add/compare step writes the
// result register; the rate is set only by downstream tready.
// Depends on hlcd_pkg, hlcd_in_reg, hlcd_parser, hlcd_out_reg and the defines header.
`include "header_length_checksum_deframer_defines.svh"

module header_length_checksum_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,  // header_value
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [15:8] byte_index
    output logic        m_axis_tlast,   // last_of_packet
    output logic [0:0]  m_axis_tuser    // [0] packet_good
);

    hlcd_pkg::t_stage  stage;
    hlcd_pkg::t_result result;
    logic              out_can_load;
    logic              advance;

    assign advance = stage.valid && out_can_load;

    hlcd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .i_tdata   (s_axis_tdata),
        .o_tready  (s_axis_tready),
        .i_advance (advance),
        .o_stage   (stage)
    );

    hlcd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_stage       (stage),
        .i_advance     (advance),
        .o_result      (result)
    );

    hlcd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && result.valid),
        .i_result   (result),
        .o_can_load (out_can_load),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata),
        .o_tlast    (m_axis_tlast),
        .o_tuser    (m_axis_tuser)
    );

    // empty input stage never back-pressures the source
    `HLCD_ASSERT(a_in_ready_when_empty, !stage.valid |-> s_axis_tready, "input stage empty but not ready")
    // good flag only on the closing byte of a packet
    `HLCD_NEVER(a_good_only_last, m_axis_tvalid && m_axis_tuser[0] && !m_axis_tlast, "good set on non-last item")
    // a packet closed at the length byte is always marked bad
    `HLCD_NEVER(a_short_is_bad, m_axis_tvalid && m_axis_tlast && (m_axis_tdata[15:8] == 8'd1) && m_axis_tuser[0], "short packet marked good")

endmodule
